@@ hw/rtl/bf3sat_pkg.sv @@
package bf3sat_pkg;

  localparam int MAX_VARS           = 20;
  localparam int MAX_CLAUSE_ENTRIES = 128;

  localparam int VAR_W   = 5;
  localparam int IDX_W   = $clog2(MAX_CLAUSE_ENTRIES);
  localparam int CNT_W   = 8;
  localparam int NV_W    = 5;
  localparam int REQ_W   = 2;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 32;
  localparam int CFG_I_W = 1;
  localparam int CFG_D_W = 8;

  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EVAL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [CFG_I_W-1:0] REG_NUM_VARS    = 1'd0;
  localparam logic [CFG_I_W-1:0] REG_NUM_CLAUSES = 1'd1;

  typedef logic [MAX_VARS-1:0] mask_t;

  typedef struct packed {
    logic             pos_c;
    logic             pos_b;
    logic             pos_a;
    logic [VAR_W-1:0] var_c;
    logic [VAR_W-1:0] var_b;
    logic [VAR_W-1:0] var_a;
  } clause_t;

  // variables past the mask width read as false
  function automatic logic lit_true(mask_t m, logic [VAR_W-1:0] v, logic p);
    logic [31:0] w;
    w = 32'(m);
    return w[v] == p;
  endfunction

  function automatic logic clause_true(clause_t c, mask_t m);
    return lit_true(m, c.var_a, c.pos_a) | lit_true(m, c.var_b, c.pos_b) |
           lit_true(m, c.var_c, c.pos_c);
  endfunction

endpackage

@@ hw/rtl/brute_force_3sat_solution_search.sv @@
// Brute-force 3-SAT engine over a 128-entry clause table.
// Input stream: s_axis_tuser carries the request kind (write clause,
// evaluate, search); s_axis_tdata carries the clause and the assignment.
// Output stream: one result request per input request, held in an output
// register until taken.
// Config port: cfg_we/cfg_index/cfg_data, index 0 num_vars, 1 num_clauses;
// write only while no request is in flight.
// Timing: a write goes straight to the response state, which then loads the
// output register. An evaluate reads one clause per cycle through the table's
// registered read port. A search tries each mask in turn, reading its clauses
// in order (a failing clause ends that mask early).
// One request is worked on at a time; the next is taken once the result is
// in the output register, even if the receiver has not yet taken it.
// When the receiver stalls, the result holds and the engine waits before
// posting the next one. Reset (rst, synchronous) empties the output register
// and sets num_vars to 20, num_clauses to 0; table contents are undefined
// until written.
module brute_force_3sat_solution_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [6:0] clause_index, [11:7] var_a, [16:12] var_b, [21:17] var_c,
  // [22] pos_a, [23] pos_b, [24] pos_c, [44:25] assignment, [47:45] zero
  input  logic [bf3sat_pkg::IN_W-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [bf3sat_pkg::REQ_W-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] satisfied_count, [8] all_satisfied, [9] found, [29:10] solution,
  // [31:30] zero
  output logic [bf3sat_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [bf3sat_pkg::CFG_I_W-1:0] cfg_index,
  input  logic [bf3sat_pkg::CFG_D_W-1:0] cfg_data
);
  import bf3sat_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]       state;
  logic [NV_W-1:0]  num_vars;
  logic [CNT_W-1:0] num_clauses;

  clause_t          clause_mem [MAX_CLAUSE_ENTRIES];
  clause_t          mem_q;

  logic             search;
  mask_t            mask;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_vld;
  logic             rd_last;
  logic [CNT_W-1:0] count;

  logic [CNT_W-1:0] res_count;
  logic             res_all;
  logic             res_found;
  mask_t            res_sol;

  logic [CNT_W-1:0] out_count;
  logic             out_all;
  logic             out_found;
  mask_t            out_sol;
  logic             m_valid_q;

  // request fields
  logic [IDX_W-1:0] in_idx;
  clause_t          in_clause;
  mask_t            in_assign;
  logic             in_acc;

  logic [CNT_W-1:0] used;
  logic [NV_W-1:0]  nv;
  mask_t            top;
  logic             ok;
  logic [CNT_W-1:0] count_next;

  assign in_idx          = s_axis_tdata[6:0];
  assign in_clause.var_a = s_axis_tdata[11:7];
  assign in_clause.var_b = s_axis_tdata[16:12];
  assign in_clause.var_c = s_axis_tdata[21:17];
  assign in_clause.pos_a = s_axis_tdata[22];
  assign in_clause.pos_b = s_axis_tdata[23];
  assign in_clause.pos_c = s_axis_tdata[24];
  assign in_assign       = s_axis_tdata[44:25];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign used = (num_clauses > CNT_W'(MAX_CLAUSE_ENTRIES)) ?
                CNT_W'(MAX_CLAUSE_ENTRIES) : num_clauses;
  assign nv   = (num_vars > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : num_vars;
  assign top  = MAX_VARS'(((MAX_VARS+1)'(1) << nv) - (MAX_VARS+1)'(1));

  assign ok         = clause_true(mem_q, mask);
  assign count_next = count + CNT_W'(ok);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_sol, out_found, out_all, out_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars    <= NV_W'(MAX_VARS);
      num_clauses <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_VARS:    num_vars    <= cfg_data[NV_W-1:0];
        REG_NUM_CLAUSES: num_clauses <= cfg_data;
        default: ;
      endcase
    end
  end

  // clause table: one write port for write requests, one registered read
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == REQ_WRITE) begin
      clause_mem[in_idx] <= in_clause;
    end
    mem_q <= clause_mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_valid_q <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      // in ST_RESP the output register is handled below
      if (m_valid_q && m_axis_tready && state != ST_RESP) begin
        m_valid_q <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            mask      <= in_assign;
            search    <= (s_axis_tuser == REQ_SEARCH);
            count     <= '0;
            rd_idx    <= '0;
            rd_vld    <= 1'b0;
            rd_last   <= 1'b0;
            res_count <= '0;
            res_all   <= 1'b0;
            res_found <= 1'b0;
            res_sol   <= '0;
            state     <= ST_RESP;
            priority if (s_axis_tuser == REQ_EVAL) begin
              if (used == '0) begin
                res_all <= 1'b1;
              end else begin
                state <= ST_SCAN;
              end
            end else if (s_axis_tuser == REQ_SEARCH && in_assign <= top) begin
              if (used == '0) begin
                res_all   <= 1'b1;
                res_found <= 1'b1;
                res_sol   <= in_assign;
              end else begin
                state <= ST_SCAN;
              end
            end else begin
              // write, unused kind or start past the range: all zero
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld && search && !ok) begin
            // mask fails: drop the read in flight and restart the table
            rd_vld <= 1'b0;
            rd_idx <= '0;
            if (mask == top) begin
              state <= ST_RESP;
            end else begin
              mask <= mask + MAX_VARS'(1);
            end
          end else begin
            rd_vld  <= (rd_idx < used);
            rd_last <= (rd_idx == used - CNT_W'(1));
            if (rd_idx < used) begin
              rd_idx <= rd_idx + CNT_W'(1);
            end
            if (rd_vld) begin
              if (!search) begin
                count <= count_next;
                if (rd_last) begin
                  res_count <= count_next;
                  res_all   <= (count_next == used);
                  state     <= ST_RESP;
                end
              end else if (rd_last) begin
                res_count <= used;
                res_all   <= 1'b1;
                res_found <= 1'b1;
                res_sol   <= mask;
                state     <= ST_RESP;
              end
            end
          end
        end
        ST_RESP: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            out_count <= res_count;
            out_all   <= res_all;
            out_found <= res_found;
            out_sol   <= res_sol;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/bf3sat_checker.sv @@
module bf3sat_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [bf3sat_pkg::OUT_W-1:0] m_axis_tdata
);
  import bf3sat_pkg::*;

  // one request at a time: no back-to-back accepts
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_found_all: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8])
    else $error("found without all satisfied");

  a_sol_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[29:10] == '0)
    else $error("solution set without found");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind brute_force_3sat_solution_search bf3sat_checker u_bf3sat_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
